FILE: src/bfsq_pkg.sv
`default_nettype none
package bfsq_pkg;

	localparam int MANT_W  = 31;
	localparam int EXP_W   = 16;
	localparam int Q_W     = 16;
	localparam int COEF_W  = 16;
	localparam int ROOT_W  = 16;
	localparam int IN_W    = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_C0  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C1  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C2  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ODD = 2'd3;

	localparam logic [31:0] RND_HALF = 32'h0000_8000;

	typedef struct packed {
		logic [COEF_W-1:0] c0;
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		logic [COEF_W-1:0] odd;
	} coef_t;

	typedef struct packed {
		logic [15:0]      m;
		logic             d_odd;
		logic             zero;
		logic [EXP_W-1:0] e;
		logic [Q_W-1:0]   q;
	} norm_t;

	typedef struct packed {
		logic [15:0]      v_hi;
		logic [EXP_W-1:0] e;
		logic [Q_W-1:0]   q;
	} poly_t;

endpackage
`default_nettype wire

FILE: src/bfsq_norm.sv
`default_nettype none
module bfsq_norm (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [bfsq_pkg::MANT_W-1:0]   in_mant,
	input  wire  [bfsq_pkg::EXP_W-1:0]    in_exp,
	input  wire  [bfsq_pkg::Q_W-1:0]      in_q,
	output logic                          out_valid,
	input  wire                           out_ready,
	output bfsq_pkg::norm_t               out_data
);
	import bfsq_pkg::*;

	logic [4:0]        top_pos;
	logic [4:0]        norm;
	logic [MANT_W-1:0] shifted;
	logic [EXP_W-1:0]  d;
	logic [EXP_W:0]    d_inc;
	logic              zero;
	logic              vld_s1;
	norm_t             data_s1;

	// priority encode of the top set bit
	always_comb begin
		top_pos = '0;
		for (int i = 0; i < MANT_W; i++) begin
			if (in_mant[i])
				top_pos = 5'(i);
		end
	end

	assign zero    = (in_mant == '0);
	assign norm    = 5'(MANT_W - 1) - top_pos;
	assign shifted = in_mant << norm;
	assign d       = in_exp - {11'd0, norm};
	assign d_inc   = {d[EXP_W-1], d} + 17'd1;

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.m     <= {1'b0, shifted[MANT_W-1:16]};
			data_s1.d_odd <= d[0];
			data_s1.zero  <= zero;
			data_s1.e     <= d_inc[EXP_W:1];
			data_s1.q     <= in_q;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = data_s1;

endmodule
`default_nettype wire

FILE: src/bfsq_poly.sv
`default_nettype none
module bfsq_poly (
	input  wire              clk,
	input  wire              arst_n,
	input  bfsq_pkg::coef_t  coef,
	input  wire              in_valid,
	output logic             in_ready,
	input  bfsq_pkg::norm_t  in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output bfsq_pkg::poly_t  out_data
);
	import bfsq_pkg::*;

	typedef struct packed {
		logic             d_odd;
		logic             zero;
		logic [EXP_W-1:0] e;
		logic [Q_W-1:0]   q;
	} side_t;

	// s2: m*c0, s3: h, s4: m*h, s5: acc high, s6: odd*acc, s7: rounded value
	logic              vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic              rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;
	side_t             side_s2, side_s3, side_s4, side_s5, side_s6;
	logic [15:0]       m_s2, m_s3;
	logic signed [31:0] prod_s2, prod_s4, prod_s6;
	logic [15:0]       h_s3, acc_s5, acc_s6;
	poly_t             data_s7;

	logic [31:0] t_sum, acc_sum, odd_sum;
	logic [15:0] v_hi;

	assign t_sum   = {coef.c1, 16'h0} + RND_HALF + {prod_s2[30:0], 1'b0};
	assign acc_sum = {coef.c2, 16'h0} + RND_HALF + {prod_s4[30:0], 1'b0};
	assign odd_sum = {prod_s6[30:0], 1'b0} + RND_HALF;

	always_comb begin
		if (side_s6.zero)
			v_hi = '0;
		else if (side_s6.d_odd)
			v_hi = odd_sum[31:16];
		else
			v_hi = acc_s6;
	end

	assign rdy_s7   = !vld_s7 || out_ready;
	assign rdy_s6   = !vld_s6 || rdy_s7;
	assign rdy_s5   = !vld_s5 || rdy_s6;
	assign rdy_s4   = !vld_s4 || rdy_s5;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (rdy_s2) vld_s2 <= in_valid;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
			if (rdy_s7) vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			m_s2          <= in_data.m;
			prod_s2       <= $signed(in_data.m) * $signed(coef.c0);
			side_s2.d_odd <= in_data.d_odd;
			side_s2.zero  <= in_data.zero;
			side_s2.e     <= in_data.e;
			side_s2.q     <= in_data.q;
		end
		if (rdy_s3 && vld_s2) begin
			m_s3    <= m_s2;
			h_s3    <= t_sum[31:16];
			side_s3 <= side_s2;
		end
		if (rdy_s4 && vld_s3) begin
			prod_s4 <= $signed(m_s3) * $signed(h_s3);
			side_s4 <= side_s3;
		end
		if (rdy_s5 && vld_s4) begin
			acc_s5  <= acc_sum[31:16];
			side_s5 <= side_s4;
		end
		if (rdy_s6 && vld_s5) begin
			prod_s6 <= $signed(coef.odd) * $signed(acc_s5);
			acc_s6  <= acc_s5;
			side_s6 <= side_s5;
		end
		if (rdy_s7 && vld_s6) begin
			data_s7.v_hi <= v_hi;
			data_s7.e    <= side_s6.e;
			data_s7.q    <= side_s6.q;
		end
	end

	assign out_valid = vld_s7;
	assign out_data  = data_s7;

endmodule
`default_nettype wire

FILE: src/bfsq_scale.sv
`default_nettype none
module bfsq_scale (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  bfsq_pkg::poly_t              in_data,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [bfsq_pkg::ROOT_W-1:0]  out_root
);
	import bfsq_pkg::*;

	logic              vld_s8, vld_s9, rdy_s8, rdy_s9;
	logic [15:0]       v_hi_s8;
	logic [15:0]       sh_s8;
	logic [ROOT_W-1:0] root_s9;

	logic [31:0] v;
	logic [15:0] neg_sh;
	logic [31:0] shifted;
	logic [31:0] rounded;

	assign v      = {v_hi_s8, 16'h0};
	assign neg_sh = 16'd0 - sh_s8;

	always_comb begin
		if (!sh_s8[15]) begin
			if (sh_s8 >= 16'd32)
				shifted = '0;
			else
				shifted = v << sh_s8[4:0];
		end else begin
			// negative amount; the most negative code means 32768, also a full fill
			if (neg_sh[15] || neg_sh >= 16'd32)
				shifted = {32{v[31]}};
			else
				shifted = 32'($signed(v) >>> neg_sh[4:0]);
		end
	end

	assign rounded = shifted + RND_HALF;

	assign rdy_s9   = !vld_s9 || out_ready;
	assign rdy_s8   = !vld_s8 || rdy_s9;
	assign in_ready = rdy_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (rdy_s8) vld_s8 <= in_valid;
			if (rdy_s9) vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s8 && in_valid) begin
			v_hi_s8 <= in_data.v_hi;
			sh_s8   <= in_data.e - in_data.q;
		end
		if (rdy_s9 && vld_s8)
			root_s9 <= rounded[31:16];
	end

	assign out_valid = vld_s9;
	assign out_root  = root_s9;

endmodule
`default_nettype wire

FILE: src/block_float_sqrt_to_q.sv
`default_nettype none
// Square root of a block-float operand (mantissa, exponent), returned as a rounded
// 16-bit value with q_format fraction bits. The mantissa is normalized, a quadratic
// with the Q15 coefficients coef_c0..coef_c2 approximates the root of its top 16
// bits, coef_odd corrects an odd exponent, and the result is shifted by the halved
// exponent minus q_format. A zero mantissa gives zero. One item enters per clock
// while the output does not stall; from acceptance to a valid result it passes the
// normalize stage, the three dependent 16x16 multiplies, each followed by its own
// add stage, and the final shift stages. Coefficients are written through the cfg
// port (index 0..3 = c0, c1, c2, odd) and reset to zero; write them while idle.
module block_float_sqrt_to_q (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// mantissa[30:0], exponent[46:31], q_format[62:47], zero pad[63]
	input  wire  [bfsq_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// root[15:0]
	output logic [bfsq_pkg::ROOT_W-1:0]     m_axis_tdata,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [bfsq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [bfsq_pkg::COEF_W-1:0]     cfg_data
);
	import bfsq_pkg::*;

	coef_t coef_q;

	logic  norm_valid, norm_ready;
	norm_t norm_data;
	logic  poly_valid, poly_ready;
	poly_t poly_data;
	logic  unused_pad;

	assign cfg_ready  = 1'b1;
	assign unused_pad = s_axis_tdata[IN_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_C0:  coef_q.c0  <= cfg_data;
				REG_C1:  coef_q.c1  <= cfg_data;
				REG_C2:  coef_q.c2  <= cfg_data;
				REG_ODD: coef_q.odd <= cfg_data;
			endcase
		end
	end

	bfsq_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mant   (s_axis_tdata[MANT_W-1:0]),
		.in_exp    (s_axis_tdata[MANT_W+EXP_W-1:MANT_W]),
		.in_q      (s_axis_tdata[MANT_W+EXP_W+Q_W-1:MANT_W+EXP_W]),
		.out_valid (norm_valid),
		.out_ready (norm_ready),
		.out_data  (norm_data)
	);

	bfsq_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.in_valid  (norm_valid),
		.in_ready  (norm_ready),
		.in_data   (norm_data),
		.out_valid (poly_valid),
		.out_ready (poly_ready),
		.out_data  (poly_data)
	);

	bfsq_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (poly_valid),
		.in_ready  (poly_ready),
		.in_data   (poly_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_root  (m_axis_tdata)
	);

endmodule
`default_nettype wire
